FILE: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: text console character writer, shared definitions
// Screen geometry, request/result payloads, memory request and the
// address helpers used by the controller and the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = ROWS * COLUMNS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int LIN_W  = 11;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

  // Character codes
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0]  RESET_COLOR = 8'h07;
  localparam logic [15:0] BLANK_RESET = {RESET_COLOR, CH_SPACE};

  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_FILL,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] target_row;
    logic [COL_W-1:0] target_col;
  } tcw_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic [LIN_W-1:0] cursor_linear;
    logic [15:0]      cell_data;
  } tcw_out_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       wdata;
  } tcw_mem_req_t;

  // Screen row/col to linear cursor position
  function automatic logic [LIN_W-1:0] lin_pos(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    return LIN_W'(int'(row) * COLUMNS + int'(col));
  endfunction

  // Base address of a physical row
  function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] phys);
    return ADDR_W'(int'(phys) * COLUMNS);
  endfunction

  // Logical row/col to store address, rows rotated by the top line
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] top,
                                                   input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    logic [ROW_W:0] sum;
    logic [ROW_W:0] phys;
    sum  = {1'b0, top} + {1'b0, row};
    phys = (sum >= (ROW_W+1)'(ROWS)) ? sum - (ROW_W+1)'(ROWS) : sum;
    return ADDR_W'(int'(phys) * COLUMNS + int'(col));
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tcw_cell_ram.sv
// ----------------------------------------------------------------------------
// tcw_cell_ram: character cell store
// Single-port synchronous RAM, one write or one read per cycle, read data
// registered and held until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cell_ram (
  input  wire logic                  clk_i,
  input  wire tcw_pkg::tcw_mem_req_t req_i,
  output logic [15:0]                rdata_o
);

  logic [15:0] mem_q [tcw_pkg::CELLS];
  logic [15:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl: console sequencer
// Holds cursor and top line, decodes requests, drives the cell store and
// walks rows for scroll, clear and the post-reset clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   item_valid_i,
  output logic                        item_stall_o,
  input  wire tcw_pkg::tcw_in_t       item_i,
  input  wire logic [7:0]             text_color_i,
  input  wire logic                   slot_free_i,
  output logic                        resp_valid_o,
  output tcw_pkg::tcw_out_t           resp_o,
  output tcw_pkg::tcw_mem_req_t       mem_req_o,
  input  wire logic [15:0]            mem_rdata_i
);

  localparam int RW = tcw_pkg::ROW_W;
  localparam int CW = tcw_pkg::COL_W;
  localparam int AW = tcw_pkg::ADDR_W;

  tcw_pkg::state_e  state_q, state_d;
  tcw_pkg::tcw_in_t item_q, item_d;
  logic [RW-1:0]    row_q, row_d;
  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    top_q, top_d;
  logic [AW-1:0]    fill_addr_q, fill_addr_d;
  logic [AW-1:0]    fill_end_q, fill_end_d;
  logic [15:0]      fill_data_q, fill_data_d;

  logic [15:0]   blank;
  logic [RW-1:0] tgt_row;
  logic [CW-1:0] tgt_col;
  logic [RW-1:0] top_inc;

  // Put char decode
  logic          put_we;
  logic [15:0]   put_wdata;
  logic [CW-1:0] put_wcol;
  logic [CW:0]   put_col;
  logic [RW:0]   put_row;
  logic          put_scroll;

  assign blank   = {text_color_i, tcw_pkg::CH_SPACE};
  assign tgt_row = (item_q.target_row > tcw_pkg::LAST_ROW) ? tcw_pkg::LAST_ROW
                                                           : item_q.target_row;
  assign tgt_col = (item_q.target_col > tcw_pkg::LAST_COL) ? tcw_pkg::LAST_COL
                                                           : item_q.target_col;
  assign top_inc = (top_q == tcw_pkg::LAST_ROW) ? '0 : top_q + 1'b1;

  // Cursor movement and cell write for put char
  always_comb begin
    put_we     = 1'b0;
    put_wdata  = blank;
    put_wcol   = col_q;
    put_col    = {1'b0, col_q};
    put_row    = {1'b0, row_q};
    put_scroll = 1'b0;
    case (item_q.char_code)
      tcw_pkg::CH_LF: begin
        put_col = '0;
        put_row = {1'b0, row_q} + 1'b1;
      end
      tcw_pkg::CH_CR: begin
        put_col = '0;
      end
      tcw_pkg::CH_BS: begin
        if (col_q != '0) begin
          put_we   = 1'b1;
          put_wcol = col_q - 1'b1;
          put_col  = {1'b0, col_q} - 1'b1;
        end
      end
      tcw_pkg::CH_TAB: begin
        put_col = (CW+1)'((int'(col_q) / tcw_pkg::TAB_STOP + 1) * tcw_pkg::TAB_STOP);
      end
      default: begin
        put_we    = 1'b1;
        put_wdata = {text_color_i, item_q.char_code};
        put_col   = {1'b0, col_q} + 1'b1;
      end
    endcase
    // Right edge wraps to the next row
    if (put_col >= (CW+1)'(tcw_pkg::COLUMNS)) begin
      put_col = '0;
      put_row = put_row + 1'b1;
    end
    // Past the bottom: scroll
    if (put_row >= (RW+1)'(tcw_pkg::ROWS)) begin
      put_scroll = 1'b1;
      put_row    = {1'b0, tcw_pkg::LAST_ROW};
    end
  end

  // Sequencer: next state, memory request, result
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    row_d        = row_q;
    col_d        = col_q;
    top_d        = top_q;
    fill_addr_d  = fill_addr_q;
    fill_end_d   = fill_end_q;
    fill_data_d  = fill_data_q;
    item_stall_o = 1'b1;
    resp_valid_o = 1'b0;
    mem_req_o    = '0;

    case (state_q)
      tcw_pkg::S_INIT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = fill_addr_q;
        mem_req_o.wdata = tcw_pkg::BLANK_RESET;
        if (fill_addr_q == tcw_pkg::LAST_CELL) begin
          fill_addr_d = '0;
          state_d     = tcw_pkg::S_IDLE;
        end else begin
          fill_addr_d = fill_addr_q + 1'b1;
        end
      end

      tcw_pkg::S_IDLE: begin
        item_stall_o = 1'b0;
        if (item_valid_i) begin
          item_d  = item_i;
          state_d = tcw_pkg::S_EXEC;
        end
      end

      // Nothing is applied until the output register can take the result
      tcw_pkg::S_EXEC: begin
        if (slot_free_i) begin
          case (item_q.func)
            tcw_pkg::FUNC_PUT: begin
              mem_req_o.we    = put_we;
              mem_req_o.addr  = tcw_pkg::cell_addr(top_q, row_q, put_wcol);
              mem_req_o.wdata = put_wdata;
              row_d = RW'(put_row);
              col_d = CW'(put_col);
              if (put_scroll) begin
                // new bottom row is the old top physical row
                top_d       = top_inc;
                fill_addr_d = tcw_pkg::row_base(top_q);
                fill_end_d  = tcw_pkg::row_base(top_q) + AW'(tcw_pkg::COLUMNS - 1);
                fill_data_d = blank;
                state_d     = tcw_pkg::S_FILL;
              end else begin
                resp_valid_o = 1'b1;
                state_d      = tcw_pkg::S_IDLE;
              end
            end
            tcw_pkg::FUNC_SET: begin
              row_d        = tgt_row;
              col_d        = tgt_col;
              resp_valid_o = 1'b1;
              state_d      = tcw_pkg::S_IDLE;
            end
            tcw_pkg::FUNC_CLEAR: begin
              row_d       = '0;
              col_d       = '0;
              top_d       = '0;
              fill_addr_d = '0;
              fill_end_d  = tcw_pkg::LAST_CELL;
              fill_data_d = blank;
              state_d     = tcw_pkg::S_FILL;
            end
            default: begin
              mem_req_o.re   = 1'b1;
              mem_req_o.addr = tcw_pkg::cell_addr(top_q, tgt_row, tgt_col);
              state_d        = tcw_pkg::S_READ;
            end
          endcase
        end
      end

      // Read data held in the RAM register until taken
      tcw_pkg::S_READ: begin
        if (slot_free_i) begin
          resp_valid_o = 1'b1;
          state_d      = tcw_pkg::S_IDLE;
        end
      end

      tcw_pkg::S_FILL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = fill_addr_q;
        mem_req_o.wdata = fill_data_q;
        if (fill_addr_q == fill_end_q) begin
          state_d = tcw_pkg::S_RESP;
        end else begin
          fill_addr_d = fill_addr_q + 1'b1;
        end
      end

      tcw_pkg::S_RESP: begin
        if (slot_free_i) begin
          resp_valid_o = 1'b1;
          state_d      = tcw_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = tcw_pkg::S_IDLE;
      end
    endcase
  end

  // Result payload from the updated cursor
  always_comb begin
    resp_o.cursor_row    = row_d;
    resp_o.cursor_col    = col_d;
    resp_o.cursor_linear = tcw_pkg::lin_pos(row_d, col_d);
    resp_o.cell_data     = (state_q == tcw_pkg::S_READ) ? mem_rdata_i : 16'h0000;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::S_INIT;
      row_q       <= '0;
      col_q       <= '0;
      top_q       <= '0;
      fill_addr_q <= '0;
      fill_end_q  <= '0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      top_q       <= top_d;
      fill_addr_q <= fill_addr_d;
      fill_end_q  <= fill_end_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    fill_data_q <= fill_data_d;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer: text-mode console over an 80x25 cell store
// Put char, set cursor, clear screen and read cell, with one result per
// request carrying the cursor after the operation.
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/in_stall_o    tcw_in_t   (request)
//   out      output     out_valid_o/out_stall_i  tcw_out_t  (result)
//   cfg      input      cfg_valid_i/cfg_ready_o  text_color (8 bits)
//
// Read cell makes one RAM read. A scroll walks the new bottom row, clear screen
// the whole store; the single RAM write port sets both. After reset a
// clearing pass over the whole store runs with in_stall_o high.
// The result register frees the request side: a new request is taken
// while a result is stalled; the next result waits for the register.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire tcw_pkg::tcw_in_t   in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tcw_pkg::tcw_out_t       out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_data_i
);

  logic [7:0]            text_color_q;
  logic                  out_valid_q;
  tcw_pkg::tcw_out_t     out_q;
  logic                  slot_free;
  logic                  resp_valid;
  tcw_pkg::tcw_out_t     resp;
  tcw_pkg::tcw_mem_req_t mem_req;
  logic [15:0]           mem_rdata;

  // Color register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= tcw_pkg::RESET_COLOR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      text_color_q <= cfg_data_i;
    end
  end

  // Result register
  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_valid) begin
      out_q <= resp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  tcw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_i),
    .item_stall_o (in_stall_o),
    .item_i       (in_data_i),
    .text_color_i (text_color_q),
    .slot_free_i  (slot_free),
    .resp_valid_o (resp_valid),
    .resp_o       (resp),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  tcw_cell_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks for the console writer
// Result handshake and consistency of the reported cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire tcw_pkg::tcw_out_t out_data_o
);

  // Stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // Cursor on screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.cursor_row <= tcw_pkg::LAST_ROW) &&
                    (out_data_o.cursor_col <= tcw_pkg::LAST_COL))
    else $error("cursor off screen");

  // Linear position matches row and column
  a_cursor_linear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.cursor_linear ==
      tcw_pkg::lin_pos(out_data_o.cursor_row, out_data_o.cursor_col))
    else $error("linear cursor mismatch");

endmodule

bind text_console_char_writer tcw_checker u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
